### rtl/dpd_pkg.sv
`timescale 1ns / 1ps

package dpd_pkg;

  // Field widths of the pixel and point words.
  localparam int COORD_BITS      = 12;
  localparam int DEPTH_BITS      = 16;
  localparam int RECIP_FRAC_BITS = 24;

  localparam int COLOR_W  = 8;
  localparam int CENTER_W = 16;
  localparam int CENTER_FRAC = 4;
  localparam int RECIP_W  = 24;
  localparam int XY_W     = 20;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // Arithmetic widths.
  localparam int POS_W   = COORD_BITS + CENTER_FRAC;
  localparam int MAG_W   = (POS_W > CENTER_W) ? POS_W : CENTER_W;
  localparam int P1_W    = MAG_W + RECIP_W;
  localparam int SPLIT_W = 24;
  localparam int LO_W    = SPLIT_W + DEPTH_BITS;
  localparam int HI_W    = (P1_W - SPLIT_W) + DEPTH_BITS;
  localparam int PROD_W  = P1_W + DEPTH_BITS;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SHIFT   = CENTER_FRAC + RECIP_FRAC_BITS;
  localparam int Q_W     = SUM_W - SHIFT;
  localparam int QX_W    = (Q_W > XY_W + 1) ? Q_W : XY_W + 1;

  localparam logic [DEPTH_BITS-1:0] MAX_DEPTH_RST = DEPTH_BITS'(65535);

  // Word layouts, first field in the lowest bits, padded to whole bytes.
  localparam int IN_RAW  = 2 * COORD_BITS + DEPTH_BITS + 3 * COLOR_W;
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW = 2 * XY_W + DEPTH_BITS + 3 * COLOR_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  // Offset subtract, two multiply stages, final add, saturate into the output register.
  localparam int NUM_STAGES = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DEPTH = 3'd0,
    REG_MAX_DEPTH = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_RECIP_X   = 3'd4,
    REG_RECIP_Y   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
  } side_t;

endpackage

### rtl/dpd_axis.sv
`timescale 1ns / 1ps

module dpd_axis
  import dpd_pkg::*;
(
  input  logic                  clk,
  input  pipe_ctl_t             ctl,
  input  logic [COORD_BITS-1:0] coord,
  input  logic [DEPTH_BITS-1:0] depth,
  input  logic [CENTER_W-1:0]   center,
  input  logic [RECIP_W-1:0]    recip,
  output logic [XY_W-1:0]       result
);

  logic [MAG_W-1:0]      pos_ext;
  logic [MAG_W-1:0]      ctr_ext;
  logic                  neg_nxt;
  logic [MAG_W-1:0]      mag_nxt;

  logic [MAG_W-1:0]      mag1_r;
  logic                  neg1_r;
  logic [DEPTH_BITS-1:0] dep1_r;
  logic [P1_W-1:0]       p1_r;
  logic                  neg2_r;
  logic [DEPTH_BITS-1:0] dep2_r;
  logic [LO_W-1:0]       lo_r;
  logic [HI_W-1:0]       hi_r;
  logic                  neg3_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  neg4_r;
  logic [XY_W-1:0]       res_r;

  logic [SUM_W-1:0]      sum_nxt;
  logic [QX_W-1:0]       q;
  logic [XY_W-1:0]       res_nxt;

  assign pos_ext = MAG_W'({coord, {CENTER_FRAC{1'b0}}});
  assign ctr_ext = MAG_W'(center);
  assign neg_nxt = pos_ext < ctr_ext;
  assign mag_nxt = neg_nxt ? (ctr_ext - pos_ext) : (pos_ext - ctr_ext);

  // Rounding toward minus infinity: a negative result takes the ceiling of
  // its magnitude, so the bias is added before the shift.
  assign sum_nxt = (SUM_W'(hi_r) << SPLIT_W) + SUM_W'(lo_r)
                 + (neg3_r ? SUM_W'((64'd1 << SHIFT) - 64'd1) : SUM_W'(0));

  assign q = QX_W'(sum_r[SUM_W-1:SHIFT]);

  always_comb begin
    if (neg4_r) begin
      if (q > QX_W'(64'd1 << (XY_W - 1))) begin
        res_nxt = {1'b1, {(XY_W-1){1'b0}}};
      end else begin
        res_nxt = XY_W'(0) - q[XY_W-1:0];
      end
    end else begin
      if (q > QX_W'((64'd1 << (XY_W - 1)) - 64'd1)) begin
        res_nxt = {1'b0, {(XY_W-1){1'b1}}};
      end else begin
        res_nxt = q[XY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      mag1_r <= mag_nxt;
      neg1_r <= neg_nxt;
      dep1_r <= depth;
    end
    if (ctl.load[1]) begin
      p1_r   <= P1_W'(mag1_r) * P1_W'(recip);
      neg2_r <= neg1_r;
      dep2_r <= dep1_r;
    end
    // The 40-bit partial product is split so each multiplier stays narrow.
    if (ctl.load[2]) begin
      lo_r   <= LO_W'(p1_r[SPLIT_W-1:0]) * LO_W'(dep2_r);
      hi_r   <= HI_W'(p1_r[P1_W-1:SPLIT_W]) * HI_W'(dep2_r);
      neg3_r <= neg2_r;
    end
    if (ctl.load[3]) begin
      sum_r  <= sum_nxt;
      neg4_r <= neg3_r;
    end
    if (ctl.load[4]) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

### rtl/dpd_ctrl.sv
`timescale 1ns / 1ps

module dpd_ctrl
  import dpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      keep,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output pipe_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] ready;

  // A stage takes a new word when it is empty or its own word moves on,
  // so bubbles close up behind a stalled output.
  always_comb begin
    ready[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
    valid_nxt[0] = ready[0] ? (in_valid && keep) : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = ready[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = ready[0];
  assign out_valid = valid_r[NUM_STAGES-1];
  assign ctl.load  = ready;
  assign ctl.valid = valid_r;

endmodule

### rtl/depth_pixel_deprojection_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Word fields, lowest bit first
// in_       slave      column[11:0] row[23:12] depth_mm[39:24] red green blue
// out_      master     point_x_mm[19:0] point_y_mm[39:20] point_z_mm[55:40] rgb
// cfg_      write      index 0..5, data up to 24 bits, no read-back
//
// One pixel is accepted per clock while the first stage can take it; its point passes
// through the offset subtract, the two split multiply stages, the add stage and the
// saturating output register, in that order.
// Pixels whose depth falls outside the window are accepted and never enter a stage.
// Each stage advances on its own, so a stalled output only blocks once every
// stage is full. rst_n is synchronous, clears the valid bits and resets the camera registers.

module depth_pixel_deprojection_unit
  import dpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // column, row, depth_mm, red, green, blue
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // point_x_mm, point_y_mm, point_z_mm, red, green, blue
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [DEPTH_BITS-1:0] min_depth_r;
  logic [DEPTH_BITS-1:0] max_depth_r;
  logic [CENTER_W-1:0]   center_x_r;
  logic [CENTER_W-1:0]   center_y_r;
  logic [RECIP_W-1:0]    recip_x_r;
  logic [RECIP_W-1:0]    recip_y_r;

  logic [COORD_BITS-1:0] in_col;
  logic [COORD_BITS-1:0] in_row;
  side_t                 in_side;
  logic                  keep;
  pipe_ctl_t             ctl;
  side_t                 side_r [NUM_STAGES];
  logic [XY_W-1:0]       point_x;
  logic [XY_W-1:0]       point_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r <= '0;
      max_depth_r <= MAX_DEPTH_RST;
      center_x_r  <= CENTER_W'(5120);
      center_y_r  <= CENTER_W'(3840);
      recip_x_r   <= RECIP_W'(27962);
      recip_y_r   <= RECIP_W'(27962);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_DEPTH: min_depth_r <= cfg_wdata[DEPTH_BITS-1:0];
        REG_MAX_DEPTH: max_depth_r <= cfg_wdata[DEPTH_BITS-1:0];
        REG_CENTER_X:  center_x_r  <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y:  center_y_r  <= cfg_wdata[CENTER_W-1:0];
        REG_RECIP_X:   recip_x_r   <= cfg_wdata[RECIP_W-1:0];
        REG_RECIP_Y:   recip_y_r   <= cfg_wdata[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_col        = in_tdata[COORD_BITS-1:0];
  assign in_row        = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_side.depth = in_tdata[2*COORD_BITS+DEPTH_BITS-1:2*COORD_BITS];
  assign in_side.red   = in_tdata[2*COORD_BITS+DEPTH_BITS+COLOR_W-1 -: COLOR_W];
  assign in_side.green = in_tdata[2*COORD_BITS+DEPTH_BITS+2*COLOR_W-1 -: COLOR_W];
  assign in_side.blue  = in_tdata[2*COORD_BITS+DEPTH_BITS+3*COLOR_W-1 -: COLOR_W];

  assign keep = (in_side.depth >= min_depth_r) && (in_side.depth <= max_depth_r);

  dpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .keep      (keep),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .ctl       (ctl)
  );

  dpd_axis u_axis_x (
    .clk    (clk),
    .ctl    (ctl),
    .coord  (in_col),
    .depth  (in_side.depth),
    .center (center_x_r),
    .recip  (recip_x_r),
    .result (point_x)
  );

  dpd_axis u_axis_y (
    .clk    (clk),
    .ctl    (ctl),
    .coord  (in_row),
    .depth  (in_side.depth),
    .center (center_y_r),
    .recip  (recip_y_r),
    .result (point_y)
  );

  // Depth and color ride alongside the arithmetic stages.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      side_r[0] <= in_side;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ctl.load[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_tdata = OUT_W'({side_r[NUM_STAGES-1].blue,
                             side_r[NUM_STAGES-1].green,
                             side_r[NUM_STAGES-1].red,
                             side_r[NUM_STAGES-1].depth,
                             point_y,
                             point_x});

  // The input may only stall when every stage holds a word.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&ctl.valid))
    else $error("input stalled while a stage was empty");

  // A kept pixel occupies the first stage on the next cycle.
  a_keep_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && keep) |=> ctl.valid[0])
    else $error("accepted pixel did not enter the pipeline");

  // A pixel outside the window leaves no word behind it.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !keep) |=> !ctl.valid[0])
    else $error("pixel outside the depth window entered the pipeline");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dpd_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 7;
  localparam int RUN_LIMIT        = 400000;
  localparam int SETTLE_CYCLES    = NUM_STAGES + 4;
  localparam int RANDOM_PHASES    = 7;
  localparam int PIXELS_PER_PHASE = 200;
  localparam int REPORT_LIMIT     = 10;

  // Indexes that map to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [CENTER_W-1:0] RST_CENTER_X = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y = 16'd3840;
  localparam logic [RECIP_W-1:0]  RST_RECIP    = 24'd27962;

  localparam logic [XY_W-1:0] XY_POS_LIMIT  = {1'b0, {(XY_W-1){1'b1}}};
  localparam logic [XY_W-1:0] XY_NEG_LIMIT  = {1'b1, {(XY_W-1){1'b0}}};
  localparam logic [63:0]     NEG_LIMIT_MAG = 64'd1 << (XY_W - 1);
  localparam logic [63:0]     POS_LIMIT_MAG = NEG_LIMIT_MAG - 64'd1;

  // Random scene kinds.
  localparam int SCENE_CAMERA = 0;
  localparam int SCENE_NOISE  = 1;
  localparam int SCENE_CORNER = 2;
  localparam int SCENE_SLICE  = 3;

  // Packed with the first field in the lowest bits.
  typedef struct packed {
    logic [COLOR_W-1:0]    blue;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    red;
    logic [DEPTH_BITS-1:0] depth_mm;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] column;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0]    blue;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    red;
    logic [DEPTH_BITS-1:0] z;
    logic [XY_W-1:0]       y;
    logic [XY_W-1:0]       x;
  } point_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // column, row, depth_mm, red, green, blue
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;       // point_x_mm, point_y_mm, point_z_mm, red, green, blue
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the camera registers.
  logic [DEPTH_BITS-1:0] win_min = '0;
  logic [DEPTH_BITS-1:0] win_max = MAX_DEPTH_RST;
  logic [CENTER_W-1:0]   ctr_x = RST_CENTER_X;
  logic [CENTER_W-1:0]   ctr_y = RST_CENTER_Y;
  logic [RECIP_W-1:0]    rcp_x = RST_RECIP;
  logic [RECIP_W-1:0]    rcp_y = RST_RECIP;

  point_t pending_points[$];
  point_t got_point;
  point_t want_point;
  int     fail_count = 0;
  int     cycle_count = 0;
  int     burst_left = 0;
  int     stall_mode = 0;
  int     stall_left = 0;
  int     stall_tick = 0;

  depth_pixel_deprojection_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[depth_pixel_deprojection_unit] ERROR");
      $finish;
    end
  end

  // Lateral coordinate in mm; the shift floors, so negative values round away from zero.
  function automatic logic [XY_W-1:0] lateral_mm(input logic [COORD_BITS-1:0] coord,
                                                 input logic [CENTER_W-1:0]   center,
                                                 input logic [RECIP_W-1:0]    recip,
                                                 input logic [DEPTH_BITS-1:0] depth);
    logic [63:0] pos;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    logic        left_of_center;
    pos = 64'(coord) << CENTER_FRAC;
    left_of_center = pos < 64'(center);
    mag = left_of_center ? 64'(center) - pos : pos - 64'(center);
    prod = mag * 64'(recip) * 64'(depth);
    if (left_of_center) begin
      q = (prod + ((64'd1 << SHIFT) - 64'd1)) >> SHIFT;
      return (q > NEG_LIMIT_MAG) ? XY_NEG_LIMIT : XY_W'(64'd0 - q);
    end
    q = prod >> SHIFT;
    return (q > POS_LIMIT_MAG) ? XY_POS_LIMIT : q[XY_W-1:0];
  endfunction

  function automatic bit depth_in_window(input pixel_t p);
    return (p.depth_mm >= win_min) && (p.depth_mm <= win_max);
  endfunction

  function automatic point_t deproject_pixel(input pixel_t p);
    point_t pt;
    pt.x     = lateral_mm(p.column, ctr_x, rcp_x, p.depth_mm);
    pt.y     = lateral_mm(p.row, ctr_y, rcp_y, p.depth_mm);
    pt.z     = p.depth_mm;
    pt.red   = p.red;
    pt.green = p.green;
    pt.blue  = p.blue;
    return pt;
  endfunction

  function automatic pixel_t make_pixel(input int column, input int row, input int depth,
                                        input int red, input int green, input int blue);
    pixel_t p;
    p.column   = COORD_BITS'(column);
    p.row      = COORD_BITS'(row);
    p.depth_mm = DEPTH_BITS'(depth);
    p.red      = COLOR_W'(red);
    p.green    = COLOR_W'(green);
    p.blue     = COLOR_W'(blue);
    return p;
  endfunction

  // Most depths land in the window so that points come out; some sit on its edges.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     pick;
    int     offset;
    p.column   = COORD_BITS'($urandom);
    p.row      = COORD_BITS'($urandom);
    p.depth_mm = DEPTH_BITS'($urandom);
    p.red      = COLOR_W'($urandom);
    p.green    = COLOR_W'($urandom);
    p.blue     = COLOR_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7 && win_min <= win_max) begin
      p.depth_mm = DEPTH_BITS'($urandom_range(win_min, win_max));
    end else if (pick < 9) begin
      case ($urandom_range(0, 3))
        0: p.depth_mm = DEPTH_BITS'(win_min - 1'b1);
        1: p.depth_mm = win_min;
        2: p.depth_mm = win_max;
        default: p.depth_mm = DEPTH_BITS'(win_max + 1'b1);
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      offset = int'($urandom_range(0, 4)) - 2;
      p.column = COORD_BITS'(int'(ctr_x >> CENTER_FRAC) + offset);
      p.row    = COORD_BITS'(int'(ctr_y >> CENTER_FRAC) - offset);
    end
    return p;
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < REPORT_LIMIT)
      $display("%s", msg);
    fail_count++;
  endtask

  // The register takes the value at the edge where cfg_wen is high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_MIN_DEPTH: win_min = data[DEPTH_BITS-1:0];
      REG_MAX_DEPTH: win_max = data[DEPTH_BITS-1:0];
      REG_CENTER_X:  ctr_x = data[CENTER_W-1:0];
      REG_CENTER_Y:  ctr_y = data[CENTER_W-1:0];
      REG_RECIP_X:   rcp_x = data[RECIP_W-1:0];
      REG_RECIP_Y:   rcp_y = data[RECIP_W-1:0];
      default: ;
    endcase
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_camera(input int lo, input int hi, input int cx, input int cy,
                            input int rx, input int ry);
    write_reg(REG_MIN_DEPTH, CFG_W'(lo));
    write_reg(REG_MAX_DEPTH, CFG_W'(hi));
    write_reg(REG_CENTER_X, CFG_W'(cx));
    write_reg(REG_CENTER_Y, CFG_W'(cy));
    write_reg(REG_RECIP_X, CFG_W'(rx));
    write_reg(REG_RECIP_Y, CFG_W'(ry));
  endtask

  // Handshake is sampled at the falling edge, where both sides are settled.
  task automatic send_pixel(input pixel_t p);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(p);
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    if (depth_in_window(p))
      pending_points.insert(pending_points.size(), deproject_pixel(p));
  endtask

  // Dropped pixels leave no trace in the queue, so allow the pipe to flush them too.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_pixel(make_pixel(320, 240, 1000, 1, 2, 3));
    send_pixel(make_pixel(0, 0, 65535, 0, 0, 0));
    send_pixel(make_pixel(4095, 4095, 65535, 255, 255, 255));
    send_pixel(make_pixel(4095, 0, 0, 170, 85, 170));
    // One pixel off center at depth 1: the tiny negative row product must floor to -1.
    send_pixel(make_pixel(321, 239, 1, 85, 170, 85));
    send_pixel(make_pixel(2730, 1365, 43690, 15, 240, 204));
    wait_idle();
  endtask

  task automatic test_depth_window();
    set_camera(500, 2000, 5120, 3840, 27962, 27962);
    send_pixel(make_pixel(100, 100, 499, 10, 20, 30));
    send_pixel(make_pixel(100, 100, 500, 10, 20, 30));
    send_pixel(make_pixel(500, 400, 2000, 40, 50, 60));
    send_pixel(make_pixel(500, 400, 2001, 40, 50, 60));
    wait_idle();
    // Minimum above maximum keeps nothing.
    set_camera(3000, 2999, 5120, 3840, 27962, 27962);
    send_pixel(make_pixel(1, 2, 2999, 1, 1, 1));
    send_pixel(make_pixel(1, 2, 3000, 1, 1, 1));
    send_pixel(make_pixel(1, 2, 0, 1, 1, 1));
    wait_idle();
    set_camera(65535, 65535, 5120, 3840, 27962, 27962);
    send_pixel(make_pixel(7, 9, 65535, 9, 8, 7));
    send_pixel(make_pixel(7, 9, 65534, 9, 8, 7));
    wait_idle();
  endtask

  task automatic test_saturation_and_zero_focal();
    set_camera(0, 65535, 65535, 0, 16777215, 16777215);
    send_pixel(make_pixel(0, 4095, 65535, 255, 0, 255));
    send_pixel(make_pixel(4095, 0, 65535, 0, 255, 0));
    wait_idle();
    write_reg(REG_RECIP_X, '0);
    send_pixel(make_pixel(0, 4095, 65535, 12, 34, 56));
    wait_idle();
    // Writes to unused indexes must leave every register alone.
    write_reg(REG_SPARE_LO, {CFG_W{1'b1}});
    write_reg(REG_SPARE_HI, '0);
    send_pixel(make_pixel(2048, 2048, 30000, 78, 90, 12));
    send_pixel(make_pixel(0, 0, 1, 3, 4, 5));
    wait_idle();
  endtask

  task automatic random_camera(input int kind);
    int lo;
    case (kind)
      SCENE_CAMERA: begin
        set_camera($urandom_range(0, 1000), $urandom_range(2000, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   (1 << RECIP_FRAC_BITS) / $urandom_range(200, 2000),
                   (1 << RECIP_FRAC_BITS) / $urandom_range(200, 2000));
      end
      SCENE_NOISE: begin
        // Full-width data also checks that narrow registers drop the upper bits.
        write_reg(REG_MIN_DEPTH, CFG_W'($urandom) >> 1);
        write_reg(REG_MAX_DEPTH, CFG_W'($urandom) | CFG_W'(16'h8000));
        write_reg(REG_CENTER_X, CFG_W'($urandom));
        write_reg(REG_CENTER_Y, CFG_W'($urandom));
        write_reg(REG_RECIP_X, CFG_W'($urandom));
        write_reg(REG_RECIP_Y, CFG_W'($urandom));
        write_reg(REG_SPARE_LO, CFG_W'($urandom));
      end
      SCENE_CORNER: begin
        if ($urandom_range(0, 1) == 0)
          set_camera(0, 65535, 0, 65535, 16777215, 0);
        else
          set_camera(0, 65535, 65535, 0, 0, 16777215);
      end
      default: begin
        lo = $urandom_range(0, 65000);
        set_camera(lo, lo + $urandom_range(0, 500), $urandom_range(0, 65535),
                   $urandom_range(0, 65535),
                   (1 << RECIP_FRAC_BITS) / $urandom_range(200, 2000),
                   (1 << RECIP_FRAC_BITS) / $urandom_range(200, 2000));
      end
    endcase
  endtask

  task automatic test_random_scenes();
    int kind;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = (phase <= SCENE_SLICE) ? phase : $urandom_range(SCENE_CAMERA, SCENE_SLICE);
      random_camera(kind);
      for (int n = 0; n < PIXELS_PER_PHASE; n++)
        send_pixel(random_pixel());
      wait_idle();
    end
  endtask

  // The receiver switches among full speed, light and heavy stalls and a fixed duty cycle.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((stall_tick % 16) < 11);
    endcase
  end

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_point = point_t'(out_tdata);
      if (pending_points.size() == 0) begin
        note_failure($sformatf("unexpected point x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                               $signed(got_point.x), $signed(got_point.y), got_point.z,
                               got_point.red, got_point.green, got_point.blue));
      end else begin
        want_point = pending_points.pop_front();
        if (got_point.x !== want_point.x || got_point.y !== want_point.y ||
            got_point.z !== want_point.z || got_point.red !== want_point.red ||
            got_point.green !== want_point.green || got_point.blue !== want_point.blue) begin
          note_failure($sformatf(
              "point mismatch: expected x=%0d y=%0d z=%0d rgb=%02h%02h%02h, got x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
              $signed(want_point.x), $signed(want_point.y), want_point.z,
              want_point.red, want_point.green, want_point.blue,
              $signed(got_point.x), $signed(got_point.y), got_point.z,
              got_point.red, got_point.green, got_point.blue));
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_depth_window();
    test_saturation_and_zero_focal();
    test_random_scenes();
    wait_idle();
    if (fail_count == 0 && pending_points.size() == 0)
      $display("[depth_pixel_deprojection_unit] OK");
    else
      $display("[depth_pixel_deprojection_unit] ERROR");
    $finish;
  end

endmodule
